/* design/csa_pkg.sv */
package csa_pkg;

  // store sizes
  localparam int unsigned VECTOR_DEPTH = 4096;
  localparam int unsigned ROW_DEPTH    = 4096;
  localparam int unsigned TILE_COUNT   = 2;

  // field and address widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned TW_W     = 13;
  localparam int unsigned TILE_W   = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int unsigned VEC_AW   = $clog2(VECTOR_DEPTH);
  localparam int unsigned ROW_AW   = $clog2(ROW_DEPTH);
  localparam int unsigned VA_SUM_W = TILE_W + TW_W + 1;

  localparam logic [TW_W-1:0] TILE_COLS_RST = TW_W'(2048);

  typedef logic [DATA_W-1:0] word_t;

  // request opcodes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_READ    = 2'd2
  } opcode_e;

  // output store init sweep
  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } clr_state_e;

  // vector store access
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [TILE_W-1:0] tile_index;
    logic [IDX_W-1:0]  column_index;
    word_t             wr_data;
  } vec_cmd_t;

  // output store access
  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    word_t             wr_data;
  } row_cmd_t;

endpackage

/* design/csa_ifs.sv */
interface csa_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [csa_pkg::TILE_W-1:0]        tile_index;
  logic [csa_pkg::IDX_W-1:0]         row_index;
  logic [csa_pkg::IDX_W-1:0]         column_index;
  logic signed [csa_pkg::DATA_W-1:0] operand_value;
  logic                              row_last;

  modport source (
    output valid, opcode, tile_index, row_index, column_index, operand_value, row_last,
    input  ready
  );
  modport sink (
    input  valid, opcode, tile_index, row_index, column_index, operand_value, row_last,
    output ready
  );
endinterface

interface csa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [csa_pkg::DATA_W-1:0] row_result;

  modport source (
    output valid, row_result,
    input  ready
  );
  modport sink (
    input  valid, row_result,
    output ready
  );
endinterface

interface csa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [csa_pkg::TW_W-1:0]   tile_cols;

  modport source (
    output valid, tile_cols,
    input  ready
  );
  modport sink (
    input  valid, tile_cols,
    output ready
  );
endinterface

/* design/csr_spmv_accumulator.sv */
// Streaming CSR sparse matrix-vector multiply with 32-bit wrapping integer math. A load
// request writes x[column_index]; a nonzero request multiplies operand_value by
// x[tile_index * tile_cols + column_index] into a running row sum, and on row_last adds
// that sum into y[row_index] and clears it; a read request returns y[row_index] as
// row_result. After reset the block sweeps all 4096 rows of the output store to zero,
// one row a cycle; req_i.ready stays low meanwhile (cfg_i is taken at all times).
// After that it accepts one request per cycle unless the pipeline is held: a request
// flows through the stages (vector store read, multiply, accumulate and output store
// read-modify-write), and a read result lands in the output register. A read that
// reaches the last stage while the previous result still waits on rsp_o holds the
// pipeline while rsp_o.ready stays low. Write tile_cols only while the block is idle.
module csr_spmv_accumulator (
  input  logic      clk_i,
  input  logic      rst_ni,
  csa_cfg_if.sink   cfg_i,
  csa_req_if.sink   req_i,
  csa_rsp_if.source rsp_o
);

  logic [csa_pkg::TW_W-1:0]   tile_cols_q;
  csa_pkg::vec_cmd_t          vec_cmd;
  csa_pkg::word_t             vec_rdata;
  csa_pkg::row_cmd_t          row_cmd;
  csa_pkg::word_t             row_rdata;
  logic                       clr_busy;
  logic                       adv;
  logic                       accept;
  logic                       is_nz;
  logic                       is_rd;

  // stage 1: vector operand arrives
  logic                       s1_valid_q;
  logic                       s1_nz_q;
  logic                       s1_last_q;
  logic [csa_pkg::ROW_AW-1:0] s1_row_q;
  csa_pkg::word_t             s1_val_q;

  // stage 2: accumulate and output store update
  logic                       s2_valid_q;
  logic                       s2_nz_q;
  logic                       s2_last_q;
  logic [csa_pkg::ROW_AW-1:0] s2_row_q;
  csa_pkg::word_t             s2_prod_q;
  csa_pkg::word_t             prod;

  csa_pkg::word_t             sum_q, sum_d;
  csa_pkg::word_t             sum_new;
  logic                       out_valid_q, out_valid_d;
  csa_pkg::word_t             out_data_q;
  logic                       s2_commit;
  logic                       s2_read;

  // config register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_cols_q <= csa_pkg::TILE_COLS_RST;
    end else if (cfg_i.valid) begin
      tile_cols_q <= cfg_i.tile_cols;
    end
  end

  // pipeline holds only when a read in stage 2 finds the output register taken
  assign adv         = !(s2_valid_q && !s2_nz_q && out_valid_q && !rsp_o.ready);
  assign req_i.ready = adv && !clr_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign is_nz       = (req_i.opcode == csa_pkg::OP_NONZERO);
  assign is_rd       = (req_i.opcode == csa_pkg::OP_READ);

  // vector store access
  always_comb begin
    vec_cmd.wr_en        = accept && (req_i.opcode == csa_pkg::OP_LOAD);
    vec_cmd.rd_en        = accept && is_nz;
    vec_cmd.tile_index   = req_i.tile_index;
    vec_cmd.column_index = req_i.column_index;
    vec_cmd.wr_data      = req_i.operand_value;
  end

  csa_vec_store u_vec_store (
    .clk_i       (clk_i),
    .tile_cols_i (tile_cols_q),
    .cmd_i       (vec_cmd),
    .rd_data_o   (vec_rdata)
  );

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && (is_nz || is_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_nz_q   <= is_nz;
      s1_last_q <= req_i.row_last;
      s1_row_q  <= req_i.row_index[csa_pkg::ROW_AW-1:0];
      s1_val_q  <= req_i.operand_value;
    end
  end

  // multiply, low word only
  assign prod = vec_rdata * s1_val_q;

  // stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_nz_q   <= s1_nz_q;
      s2_last_q <= s1_last_q;
      s2_row_q  <= s1_row_q;
      s2_prod_q <= prod;
    end
  end

  // running sum and row commit
  assign sum_new   = sum_q + s2_prod_q;
  assign s2_commit = adv && s2_valid_q && s2_nz_q && s2_last_q;
  assign s2_read   = adv && s2_valid_q && !s2_nz_q;

  always_comb begin
    sum_d = sum_q;
    if (adv && s2_valid_q && s2_nz_q) begin
      sum_d = s2_last_q ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // output store read at stage 1 to 2 move, write back at stage 2
  always_comb begin
    row_cmd.rd_en   = adv;
    row_cmd.rd_addr = s1_row_q;
    row_cmd.wr_en   = s2_commit;
    row_cmd.wr_addr = s2_row_q;
    row_cmd.wr_data = row_rdata + sum_new;
  end

  csa_row_store u_row_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (row_cmd),
    .rd_data_o (row_rdata),
    .busy_o    (clr_busy)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_read) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_read) begin
      out_data_q <= row_rdata;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.row_result = out_data_q;

  // a read leaves stage 2 only into a free output slot
  a_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_read |-> (!out_valid_q || rsp_o.ready))
    else $error("read result overwrote a pending result");

  // committing a row leaves the running sum cleared
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_commit |=> (sum_q == '0))
    else $error("running sum not cleared after row commit");

  // nothing moves through the pipeline during the init sweep
  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> (!s1_valid_q && !s2_valid_q && !out_valid_q))
    else $error("pipeline active during output store sweep");

endmodule

/* design/csa_vec_store.sv */
module csa_vec_store (
  input  logic                     clk_i,
  input  logic [csa_pkg::TW_W-1:0] tile_cols_i,
  input  csa_pkg::vec_cmd_t        cmd_i,
  output csa_pkg::word_t           rd_data_o
);

  csa_pkg::word_t                     mem [csa_pkg::VECTOR_DEPTH];
  csa_pkg::word_t                     rd_data_q;
  logic [csa_pkg::VA_SUM_W-1:0]       rd_sum;
  logic [csa_pkg::VA_SUM_W-1:0]       wr_sum;
  logic [csa_pkg::VEC_AW-1:0]         rd_addr;
  logic [csa_pkg::VEC_AW-1:0]         wr_addr;

  // reads use tile base plus column, writes use column alone; both wrap to the store depth
  assign rd_sum  = csa_pkg::VA_SUM_W'(cmd_i.tile_index) * csa_pkg::VA_SUM_W'(tile_cols_i)
                 + csa_pkg::VA_SUM_W'(cmd_i.column_index);
  assign wr_sum  = csa_pkg::VA_SUM_W'(cmd_i.column_index);
  assign rd_addr = rd_sum[csa_pkg::VEC_AW-1:0];
  assign wr_addr = wr_sum[csa_pkg::VEC_AW-1:0];

  // single write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= cmd_i.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/csa_row_store.sv */
module csa_row_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csa_pkg::row_cmd_t cmd_i,
  output csa_pkg::word_t    rd_data_o,
  output logic              busy_o
);

  csa_pkg::word_t             mem [csa_pkg::ROW_DEPTH];
  csa_pkg::word_t             mem_rd_q;
  logic [csa_pkg::ROW_AW-1:0] rd_addr_q;
  csa_pkg::clr_state_e        state_q, state_d;
  logic [csa_pkg::ROW_AW-1:0] cnt_q, cnt_d;
  logic                       last_cnt;
  logic                       wr_en;
  logic [csa_pkg::ROW_AW-1:0] wr_addr;
  csa_pkg::word_t             wr_data;
  logic                       fwd_vld_q;
  logic [csa_pkg::ROW_AW-1:0] fwd_addr_q;
  csa_pkg::word_t             fwd_data_q;

  assign last_cnt = (cnt_q == csa_pkg::ROW_AW'(csa_pkg::ROW_DEPTH - 1));

  // init sweep next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      csa_pkg::CLR_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (last_cnt) begin
          state_d = csa_pkg::CLR_DONE;
        end
      end
      csa_pkg::CLR_DONE: begin
        cnt_d = cnt_q;
      end
      default: begin
        state_d = csa_pkg::CLR_SWEEP;
      end
    endcase
  end

  // write port select: zero fill during sweep, else pipeline write
  always_comb begin
    busy_o  = 1'b0;
    wr_en   = cmd_i.wr_en;
    wr_addr = cmd_i.wr_addr;
    wr_data = cmd_i.wr_data;
    case (state_q)
      csa_pkg::CLR_SWEEP: begin
        busy_o  = 1'b1;
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        wr_data = '0;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csa_pkg::CLR_SWEEP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      mem_rd_q  <= mem[cmd_i.rd_addr];
      rd_addr_q <= cmd_i.rd_addr;
    end
  end

  // last write kept to cover a read issued on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (wr_en) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

  assign rd_data_o = (fwd_vld_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : mem_rd_q;

  // sweep runs once after reset
  a_sweep_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csa_pkg::CLR_DONE) |=> (state_q == csa_pkg::CLR_DONE))
    else $error("output store sweep restarted");

endmodule
